/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define PDAM_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define PDAM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/pdam_pkg.sv */
package pdam_pkg;

	localparam int ADC_W      = 10;
	localparam int NUM_FIELDS = 5;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int TRIG_W     = 8;
	localparam int STICK_W    = 16;
	localparam int DIVR_W     = 10;
	localparam int PROD_W     = ADC_W + STICK_W;

	typedef logic [ADC_W-1:0]          adc_t;
	typedef logic [TRIG_W-1:0]         trig_t;
	typedef logic signed [STICK_W-1:0] stick_t;
	typedef logic [CFG_W-1:0]          cfg_data_t;
	typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER    = 3'd0,
		REG_MAX       = 3'd1,
		REG_DEAD_BAND = 3'd2,
		REG_STICK_MIN = 3'd3,
		REG_STICK_MAX = 3'd4
	} reg_idx_t;

	localparam adc_t   CENTER_RST    = 10'd512;
	localparam adc_t   MAX_RST       = 10'd1023;
	localparam adc_t   DEAD_BAND_RST = 10'd10;
	localparam stick_t STICK_MIN_RST = -16'sd32768;
	localparam stick_t STICK_MAX_RST = 16'sd32767;
	localparam trig_t  TRIG_FULL     = 8'd255;

endpackage

/* rtl/core/pot_deadzone_axis_mapper_core.sv */
// Potentiometer axis mapper with dead band.
// Input channel (in_valid/in_ready) carries five raw samples and a mode bit;
// the output channel (out_valid/out_ready) carries the held trigger and stick
// values and a moved flag, one result per input transfer.
// The configuration port (cfg_we/cfg_index/cfg_data) writes centre, max, dead
// band and stick bounds; write it only while the block is idle.
// One restoring divider, one quotient bit per cycle, does all the work: first
// the sample average, then the axis map, with a set-up step between them and
// a finishing step after the map. out_valid rises with the result, and in_ready
// rises again in the same cycle. in_ready is low while an item is at work.
// The result sits in an output register: a new item is taken while it waits,
// and a finished item waits in its last step until the receiver takes the
// previous result. Reset restores the register defaults, sets the last
// accepted value to 512 and clears the held outputs.
module pot_deadzone_axis_mapper_core #(
	parameter int SAMPLES  = 5,
	parameter int ADC_BITS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  pdam_pkg::cfg_idx_t  cfg_index,
	input  pdam_pkg::cfg_data_t cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  pdam_pkg::adc_t      sample_a,
	input  pdam_pkg::adc_t      sample_b,
	input  pdam_pkg::adc_t      sample_c,
	input  pdam_pkg::adc_t      sample_d,
	input  pdam_pkg::adc_t      sample_e,
	input  logic               trigger_mode,
	output logic               out_valid,
	input  logic               out_ready,
	output pdam_pkg::trig_t     left_trigger,
	output pdam_pkg::trig_t     right_trigger,
	output pdam_pkg::stick_t    stick_y,
	output logic               moved
);
	import pdam_pkg::*;

	localparam int NUM_USED = (SAMPLES < NUM_FIELDS) ? SAMPLES : NUM_FIELDS;
	localparam int SUM_W    = $clog2(NUM_USED * ((1 << ADC_W) - 1) + 1);
	localparam int MASK_W   = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
	localparam adc_t SMASK  = ADC_W'((1 << MASK_W) - 1);
	localparam int CNT_W    = $clog2(PROD_W + 1);
	localparam int VW       = PROD_W + 2;
	localparam logic [DIVR_W-1:0] AVG_DIVR = DIVR_W'(SAMPLES);
	localparam logic [DIVR_W-1:0] ONE_DIVR = DIVR_W'(1);
	localparam logic signed [VW-1:0] V_TRIG_MAX  = VW'(255);
	localparam logic signed [VW-1:0] V_STICK_MAX = VW'(32767);
	localparam logic signed [VW-1:0] V_STICK_MIN = -VW'(32768);

	typedef enum logic [2:0] {S_IDLE, S_AVG, S_PREP, S_MAP, S_FIN} state_t;
	typedef enum logic [1:0] {K_LEFT, K_RIGHT, K_STICK} kind_t;

	state_t state_q;
	kind_t  kind_q;
	logic   trig_q;
	logic   neg_q;
	logic   moved_q;
	adc_t   pot_q;

	adc_t   center_q;
	adc_t   max_q;
	adc_t   dead_q;
	stick_t smin_q;
	stick_t smax_q;

	adc_t   last_q;
	trig_t  held_left_q;
	trig_t  held_right_q;
	stick_t held_stick_q;
	logic   moved_out_q;
	logic   out_valid_q;

	logic [PROD_W-1:0] dvd_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] divr_q;
	logic [CNT_W-1:0]  cnt_q;

	// averaging
	adc_t              smp [NUM_FIELDS];
	logic [SUM_W-1:0]  sum;

	// divider step
	logic [DIVR_W:0]   rem_sh;
	logic              q_bit;
	logic [DIVR_W-1:0] rem_nx;
	logic [PROD_W-1:0] dvd_nx;

	// set-up
	adc_t              pot;
	adc_t              diff_abs;
	logic              moved_c;
	logic              below;
	logic signed [STICK_W:0] rng;
	logic              rng_neg;
	logic [STICK_W-1:0] rng_mag;
	adc_t              mul_a;
	logic [STICK_W-1:0] mul_b;
	logic [DIVR_W-1:0] divr_c;
	kind_t             kind_c;

	// finish
	logic signed [VW-1:0] qx;
	logic signed [VW-1:0] v;
	trig_t             v_trig;
	stick_t            v_stick;

	assign smp[0] = sample_a;
	assign smp[1] = sample_b;
	assign smp[2] = sample_c;
	assign smp[3] = sample_d;
	assign smp[4] = sample_e;

	always_comb begin
		sum = '0;
		for (int i = 0; i < NUM_USED; i++) begin
			sum = sum + SUM_W'(smp[i] & SMASK);
		end
	end

	always_comb begin
		rem_sh = {rem_q, dvd_q[PROD_W-1]};
		q_bit  = (rem_sh >= {1'b0, divr_q});
		rem_nx = q_bit ? DIVR_W'(rem_sh - {1'b0, divr_q}) : rem_sh[DIVR_W-1:0];
		dvd_nx = {dvd_q[PROD_W-2:0], q_bit};
	end

	always_comb begin
		pot      = dvd_q[ADC_W-1:0];
		diff_abs = (pot >= last_q) ? (pot - last_q) : (last_q - pot);
		moved_c  = (diff_abs > dead_q);
		below    = (pot < center_q);
		rng      = {smax_q[STICK_W-1], smax_q} - {smin_q[STICK_W-1], smin_q};
		rng_neg  = rng[STICK_W];
		rng_mag  = rng_neg ? STICK_W'(-rng) : STICK_W'(rng);
		mul_a    = pot;
		mul_b    = STICK_W'(TRIG_FULL);
		divr_c   = ONE_DIVR;
		kind_c   = K_STICK;
		if (trig_q) begin
			if (below) begin
				kind_c = K_LEFT;
				if (center_q == ADC_W'(1)) begin
					mul_a = '0;
				end else begin
					divr_c = DIVR_W'(center_q - ADC_W'(1));
				end
			end else begin
				kind_c = K_RIGHT;
				if (max_q == center_q) begin
					mul_a = ADC_W'(1);
				end else if (max_q < center_q) begin
					mul_a = '0;
				end else begin
					mul_a  = pot - center_q;
					divr_c = DIVR_W'(max_q - center_q);
				end
			end
		end else begin
			mul_b = rng_mag;
			if (max_q == '0) begin
				mul_a = ADC_W'(1);
			end else begin
				divr_c = DIVR_W'(max_q);
			end
		end
	end

	always_comb begin
		qx = VW'(dvd_q);
		case (kind_q)
			K_LEFT:  v = V_TRIG_MAX - qx;
			K_RIGHT: v = qx;
			default: v = (neg_q ? -qx : qx) + VW'(smin_q);
		endcase
		if (v < 0) begin
			v_trig = '0;
		end else if (v > V_TRIG_MAX) begin
			v_trig = TRIG_FULL;
		end else begin
			v_trig = v[TRIG_W-1:0];
		end
		if (v < V_STICK_MIN) begin
			v_stick = V_STICK_MIN[STICK_W-1:0];
		end else if (v > V_STICK_MAX) begin
			v_stick = V_STICK_MAX[STICK_W-1:0];
		end else begin
			v_stick = v[STICK_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			kind_q       <= K_LEFT;
			trig_q       <= 1'b0;
			neg_q        <= 1'b0;
			moved_q      <= 1'b0;
			pot_q        <= '0;
			center_q     <= CENTER_RST;
			max_q        <= MAX_RST;
			dead_q       <= DEAD_BAND_RST;
			smin_q       <= STICK_MIN_RST;
			smax_q       <= STICK_MAX_RST;
			last_q       <= CENTER_RST;
			held_left_q  <= '0;
			held_right_q <= '0;
			held_stick_q <= '0;
			moved_out_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			dvd_q        <= '0;
			rem_q        <= '0;
			divr_q       <= '0;
			cnt_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_CENTER:    center_q <= cfg_data[ADC_W-1:0];
					REG_MAX:       max_q    <= cfg_data[ADC_W-1:0];
					REG_DEAD_BAND: dead_q   <= cfg_data[ADC_W-1:0];
					REG_STICK_MIN: smin_q   <= stick_t'(cfg_data[STICK_W-1:0]);
					REG_STICK_MAX: smax_q   <= stick_t'(cfg_data[STICK_W-1:0]);
					default: ;
				endcase
			end
			if (out_valid_q && out_ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						dvd_q   <= PROD_W'(sum) << (PROD_W - SUM_W);
						rem_q   <= '0;
						divr_q  <= AVG_DIVR;
						cnt_q   <= CNT_W'(SUM_W);
						trig_q  <= trigger_mode;
						state_q <= S_AVG;
					end
				end
				S_AVG: begin
					dvd_q <= dvd_nx;
					rem_q <= rem_nx;
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					pot_q   <= pot;
					moved_q <= moved_c;
					kind_q  <= kind_c;
					neg_q   <= rng_neg;
					dvd_q   <= mul_a * mul_b;
					rem_q   <= '0;
					divr_q  <= divr_c;
					cnt_q   <= CNT_W'(PROD_W);
					state_q <= S_MAP;
				end
				S_MAP: begin
					dvd_q <= dvd_nx;
					rem_q <= rem_nx;
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					// hold until the previous result has been taken
					if (!out_valid_q || out_ready) begin
						if (trig_q) begin
							held_stick_q <= '0;
							if (moved_q) begin
								held_left_q  <= (kind_q == K_LEFT) ? v_trig : '0;
								held_right_q <= (kind_q == K_RIGHT) ? v_trig : '0;
							end
						end else begin
							held_left_q  <= '0;
							held_right_q <= '0;
							if (moved_q) begin
								held_stick_q <= v_stick;
							end
						end
						if (moved_q) begin
							last_q <= pot_q;
						end
						moved_out_q <= moved_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign left_trigger  = held_left_q;
	assign right_trigger = held_right_q;
	assign stick_y       = held_stick_q;
	assign moved         = moved_out_q;

endmodule

/* rtl/core/pdam_checker.sv */
`include "assert_macros.svh"

module pdam_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input pdam_pkg::trig_t     left_trigger,
	input pdam_pkg::trig_t     right_trigger,
	input pdam_pkg::stick_t    stick_y,
	input logic               moved
);
	import pdam_pkg::*;

	`PDAM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(moved) && $stable(stick_y), "result dropped or changed while stalled")
	`PDAM_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "input taken while an item is at work")
	`PDAM_ASSERT(a_one_trigger, !out_valid || left_trigger == '0 || right_trigger == '0, "both triggers active")
	`PDAM_ASSERT(a_mode_excl, !out_valid || stick_y == '0 || (left_trigger == '0 && right_trigger == '0), "stick and trigger both active")

endmodule

bind pot_deadzone_axis_mapper_core pdam_checker u_pdam_checker (.*);
